[hdl/wave_equation_stencil_step_macros.svh]
// Assertion macros shared by the stencil step RTL.
`ifndef WAVE_EQUATION_STENCIL_STEP_MACROS_SVH
`define WAVE_EQUATION_STENCIL_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define WES_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define WES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wes_pkg.sv]
// Types, constants and arithmetic helpers of the wave equation stencil step.
package wes_pkg;

  localparam int VALUE_W    = 32;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int GAMMA_W    = 17;
  localparam int MAX_COLS   = 1 << COL_W;
  localparam int MID_DEPTH  = 2 * MAX_COLS;
  localparam int MID_AW     = COL_W + 1;
  localparam int LAP_W      = VALUE_W + 2;
  localparam int PROD_W     = LAP_W + GAMMA_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_STEP  = 16;
  localparam int FRAC_START = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAMMA_W;

  localparam logic [ROW_W-1:0]   GRID_ROWS_RST  = ROW_W'(10);
  localparam logic [COL_W-1:0]   GRID_COLS_RST  = COL_W'(10);
  localparam logic [GAMMA_W-1:0] GAMMA_RST      = GAMMA_W'(16384);

  localparam logic signed [SUM_W-1:0] RND_STEP  = SUM_W'(1) <<< (FRAC_STEP - 1);
  localparam logic signed [SUM_W-1:0] RND_START = SUM_W'(1) <<< (FRAC_START - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI    = (SUM_W'(1) <<< (VALUE_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO    = -SAT_HI - SUM_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS,
    CFG_GRID_COLS,
    CFG_GAMMA_ROW,
    CFG_GAMMA_COL,
    CFG_START_MODE
  } cfg_reg_e;

  // Line store write/read request for one accepted grid point
  typedef struct packed {
    logic                      en;
    logic                      bank;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] mid;
    logic signed [VALUE_W-1:0] bot;
  } store_req_t;

  // Neighborhood read back from the line stores
  typedef struct packed {
    logic signed [VALUE_W-1:0] up;
    logic signed [VALUE_W-1:0] center;
    logic signed [VALUE_W-1:0] left;
    logic signed [VALUE_W-1:0] right;
    logic signed [VALUE_W-1:0] bot;
  } store_rd_t;

  // Drop the fraction bits (rounding half added earlier), clamp to value range.
  function automatic logic signed [VALUE_W-1:0] round_sat(
    input logic signed [SUM_W-1:0] total,
    input logic                    start
  );
    logic signed [SUM_W-1:0] shifted;
    shifted = start ? (total >>> FRAC_START) : (total >>> FRAC_STEP);
    if (shifted > SAT_HI) begin
      return SAT_HI[VALUE_W-1:0];
    end else if (shifted < SAT_LO) begin
      return SAT_LO[VALUE_W-1:0];
    end
    return shifted[VALUE_W-1:0];
  endfunction

endpackage

[hdl/wes_if.sv]
// Stream and configuration channel interfaces of the stencil step.
interface wes_in_if import wes_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] mid_value;
  logic signed [VALUE_W-1:0] bot_value;

  modport source (output valid, mid_value, bot_value, input ready);
  modport sink   (input valid, mid_value, bot_value, output ready);
endinterface

interface wes_out_if import wes_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] top_value;
  logic [ROW_W-1:0]          row_index;
  logic [COL_W-1:0]          col_index;
  logic                      run_last;

  modport source (output valid, top_value, row_index, col_index, run_last, input ready);
  modport sink   (input valid, top_value, row_index, col_index, run_last, output ready);
endinterface

interface wes_cfg_if import wes_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/wes_line_store.sv]
// Line stores: two rows of current-layer values and one row of previous-layer values.
module wes_line_store
  import wes_pkg::*;
(
  input  logic       clk_i,
  input  store_req_t req_i,
  output store_rd_t  rd_o
);

  // Two copies of the mid rows give four read ports: up/center and left/right.
  logic [VALUE_W-1:0] mid_a_mem [MID_DEPTH];
  logic [VALUE_W-1:0] mid_b_mem [MID_DEPTH];
  logic [VALUE_W-1:0] bot_mem   [MAX_COLS];

  logic [MID_AW-1:0] cur_addr;
  logic [MID_AW-1:0] ctr_addr;
  logic [MID_AW-1:0] lft_addr;
  logic [MID_AW-1:0] rgt_addr;

  logic signed [VALUE_W-1:0] up_q;
  logic signed [VALUE_W-1:0] center_q;
  logic signed [VALUE_W-1:0] left_q;
  logic signed [VALUE_W-1:0] right_q;
  logic signed [VALUE_W-1:0] bot_q;

  assign cur_addr = {req_i.bank, req_i.col};
  assign ctr_addr = {~req_i.bank, req_i.col};
  assign lft_addr = {~req_i.bank, req_i.col - COL_W'(1)};
  assign rgt_addr = {~req_i.bank, req_i.col + COL_W'(1)};

  // Reads see the contents before this transfer's write
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      mid_a_mem[cur_addr] <= req_i.mid;
      up_q                <= mid_a_mem[cur_addr];
      center_q            <= mid_a_mem[ctr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      mid_b_mem[cur_addr] <= req_i.mid;
      left_q              <= mid_b_mem[lft_addr];
      right_q             <= mid_b_mem[rgt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      bot_mem[req_i.col] <= req_i.bot;
      bot_q              <= bot_mem[req_i.col];
    end
  end

  assign rd_o = '{up: up_q, center: center_q, left: left_q, right: right_q, bot: bot_q};

endmodule

[hdl/wave_equation_stencil_step.sv]
// Top level of the explicit 2-D wave equation stencil step.
`include "wave_equation_stencil_step_macros.svh"

// Grid points enter in raster order, one per cycle unless the pipeline stalls;
// each point of the previous row leaves as its next-layer value when the point
// below it enters; last-row points also leave directly as boundary copies, so
// an item on the last row below row 0 yields two results and the output side
// then sets the pace at one result per cycle while out_o is ready. A result
// goes through line store read, products, then sum/round/saturate, and waits
// in a four-entry output queue. Line stores hold 2 x 1024 current-layer and
// 1024 previous-layer values; not cleared, only used where written earlier in
// the frame. Write configuration only while no item is in flight; the user
// makes grid size changes at position (0,0), which the block does not enforce.
module wave_equation_stencil_step
  import wes_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  wes_cfg_if.sink         cfg_i,
  wes_in_if.sink          in_i,
  wes_out_if.source       out_o
);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_AW + 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] mid;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic                      has_a;
    logic                      has_b;
    logic                      interior;
  } s1_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] mid;
    logic signed [VALUE_W-1:0] center;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic                      has_a;
    logic                      has_b;
    logic                      interior;
    logic                      start;
    logic signed [SUM_W-1:0]   base;
    logic signed [PROD_W-1:0]  prod_row;
    logic signed [PROD_W-1:0]  prod_col;
  } s2_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic                      last;
  } result_t;

  // Configuration registers
  logic [ROW_W-1:0]   grid_rows_q;
  logic [COL_W-1:0]   grid_cols_q;
  logic [GAMMA_W-1:0] gamma_row_q;
  logic [GAMMA_W-1:0] gamma_col_q;
  logic               start_mode_q;

  // Raster position of the next input
  logic [ROW_W-1:0] row_pos_q, row_pos_d;
  logic [COL_W-1:0] col_pos_q, col_pos_d;
  logic             last_row;
  logic             row_end;
  logic             in_fire;

  // Pipeline
  logic       s1_valid_q, s1_valid_d;
  logic       s2_valid_q, s2_valid_d;
  s1_t        s1_q, s1_d;
  s2_t        s2_q, s2_d;
  logic       s1_go, s2_go, s2_ready, fifo_room;
  store_req_t store_req;
  store_rd_t  store_rd;

  logic signed [LAP_W-1:0]   lap_row, lap_col, mid_diff;
  logic signed [GAMMA_W:0]   g_row_s, g_col_s;
  logic signed [SUM_W-1:0]   total;
  logic signed [VALUE_W-1:0] stencil_val;
  result_t                   res_a, res_b, ent0, ent1;
  logic [1:0]                push_n;

  // Output queue
  result_t                 fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   fifo_cnt_q, fifo_cnt_d;
  logic                    pop;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= GRID_ROWS_RST;
      grid_cols_q  <= GRID_COLS_RST;
      gamma_row_q  <= GAMMA_RST;
      gamma_col_q  <= GAMMA_RST;
      start_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_GRID_ROWS:  grid_rows_q  <= cfg_i.data[ROW_W-1:0];
        CFG_GRID_COLS:  grid_cols_q  <= cfg_i.data[COL_W-1:0];
        CFG_GAMMA_ROW:  gamma_row_q  <= cfg_i.data[GAMMA_W-1:0];
        CFG_GAMMA_COL:  gamma_col_q  <= cfg_i.data[GAMMA_W-1:0];
        CFG_START_MODE: start_mode_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- position
  assign fifo_room = fifo_cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign s2_go     = s2_valid_q && fifo_room;
  assign s2_ready  = !s2_valid_q || fifo_room;
  assign s1_go     = s1_valid_q && s2_ready;
  assign in_i.ready = !s1_valid_q || s2_ready;
  assign in_fire   = in_i.valid && in_i.ready;

  assign last_row = row_pos_q >= grid_rows_q;
  assign row_end  = col_pos_q >= grid_cols_q;

  always_comb begin
    row_pos_d = row_pos_q;
    col_pos_d = col_pos_q;
    if (in_fire) begin
      if (row_end) begin
        col_pos_d = '0;
        row_pos_d = last_row ? '0 : row_pos_q + ROW_W'(1);
      end else begin
        col_pos_d = col_pos_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else begin
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign store_req = '{en: in_fire, bank: row_pos_q[0], col: col_pos_q,
                       mid: in_i.mid_value, bot: in_i.bot_value};

  wes_line_store u_line_store (
    .clk_i (clk_i),
    .req_i (store_req),
    .rd_o  (store_rd)
  );

  always_comb begin
    s1_d.mid      = in_i.mid_value;
    s1_d.row      = row_pos_q;
    s1_d.col      = col_pos_q;
    s1_d.has_a    = row_pos_q != '0;
    s1_d.has_b    = last_row;
    // Emitted row r-1 lies strictly inside the grid
    s1_d.interior = (row_pos_q >= ROW_W'(2)) && (row_pos_q <= grid_rows_q) &&
                    (col_pos_q != '0) && (col_pos_q < grid_cols_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  assign g_row_s  = $signed({1'b0, gamma_row_q});
  assign g_col_s  = $signed({1'b0, gamma_col_q});
  assign lap_row  = LAP_W'(store_rd.up) + LAP_W'(s1_q.mid) - (LAP_W'(store_rd.center) <<< 1);
  assign lap_col  = LAP_W'(store_rd.left) + LAP_W'(store_rd.right)
                  - (LAP_W'(store_rd.center) <<< 1);
  assign mid_diff = (LAP_W'(store_rd.center) <<< 1) - LAP_W'(store_rd.bot);

  always_comb begin
    s2_d.mid      = s1_q.mid;
    s2_d.center   = store_rd.center;
    s2_d.row      = s1_q.row;
    s2_d.col      = s1_q.col;
    s2_d.has_a    = s1_q.has_a;
    s2_d.has_b    = s1_q.has_b;
    s2_d.interior = s1_q.interior;
    s2_d.start    = start_mode_q;
    s2_d.prod_row = lap_row * g_row_s;
    s2_d.prod_col = lap_col * g_col_s;
    // Fold the rounding half into the base term
    if (start_mode_q) begin
      s2_d.base = (SUM_W'(store_rd.center) <<< FRAC_START) + RND_START;
    end else begin
      s2_d.base = (SUM_W'(mid_diff) <<< FRAC_STEP) + RND_STEP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_q <= s2_d;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
    if (s2_go) begin
      s2_valid_d = 1'b0;
    end
    if (s1_go) begin
      s2_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // ---------------------------------------------------------------- results
  assign total       = s2_q.base + SUM_W'(s2_q.prod_row) + SUM_W'(s2_q.prod_col);
  assign stencil_val = round_sat(total, s2_q.start);

  always_comb begin
    res_a.top  = s2_q.interior ? stencil_val : s2_q.center;
    res_a.row  = s2_q.row - ROW_W'(1);
    res_a.col  = s2_q.col;
    res_a.last = !s2_q.has_b;
    res_b.top  = s2_q.mid;
    res_b.row  = s2_q.row;
    res_b.col  = s2_q.col;
    res_b.last = 1'b1;
    ent0       = s2_q.has_a ? res_a : res_b;
    ent1       = res_b;
    push_n     = '0;
    if (s2_go) begin
      push_n = 2'(s2_q.has_a) + 2'(s2_q.has_b);
    end
  end

  // ---------------------------------------------------------------- output queue
  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d   = wr_ptr_q + FIFO_AW'(push_n);
    rd_ptr_d   = rd_ptr_q + FIFO_AW'(pop);
    fifo_cnt_d = fifo_cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr_q] <= ent0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr_q + FIFO_AW'(1)] <= ent1;
    end
  end

  assign out_o.valid     = fifo_cnt_q != '0;
  assign out_o.top_value = fifo_mem[rd_ptr_q].top;
  assign out_o.row_index = fifo_mem[rd_ptr_q].row;
  assign out_o.col_index = fifo_mem[rd_ptr_q].col;
  assign out_o.run_last  = fifo_mem[rd_ptr_q].last;

  // ---------------------------------------------------------------- checks
  `WES_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "output queue overflow")
  `WES_ASSERT_NEXT(a_s2_hold, s2_valid_q && !s2_go, s2_valid_q, "stalled stage 2 lost its item")
  `WES_ASSERT_NEXT(a_pair_follows, pop && !out_o.run_last, out_o.valid, "second result of item missing")

endmodule

[test/wave_equation_stencil_step_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the wave equation stencil step, with its own predictor.
module wave_equation_stencil_step_test;
  import wes_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef enum {FILL_SMOOTH, FILL_FULL, FILL_EXTREME, FILL_HIGH, FILL_LOW} fill_e;

  typedef struct packed {
    logic [VALUE_W-1:0] top;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               run_last;
  } grid_result_t;

  logic clk_i;
  logic rst_ni;

  wes_cfg_if cfg_bus();
  wes_in_if  point_bus();
  wes_out_if result_bus();

  wave_equation_stencil_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (point_bus),
    .out_o  (result_bus)
  );

  // Predictor copy of the registers, line stores and raster position
  logic [ROW_W-1:0]   grid_rows_q;
  logic [COL_W-1:0]   grid_cols_q;
  logic [GAMMA_W-1:0] gamma_row_q;
  logic [GAMMA_W-1:0] gamma_col_q;
  logic               start_q;
  longint             mid_lines [MID_DEPTH];
  longint             bot_line [MAX_COLS];
  int unsigned        row_pos;
  int unsigned        col_pos;

  grid_result_t pending_points[$];
  int unsigned  error_count;
  int unsigned  points_sent;
  int unsigned  burst_left;
  bit           steady_flow;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [VALUE_W-1:0] next_layer_value(
    input longint up, input longint down, input longint left, input longint right,
    input longint center, input longint prev
  );
    longint lap_r;
    longint lap_c;
    longint total;
    int     sh;
    sh = start_q ? FRAC_START : FRAC_STEP;
    lap_r = up + down - 2 * center;
    lap_c = left + right - 2 * center;
    total = ((start_q ? center : 2 * center - prev) <<< sh)
          + longint'(gamma_row_q) * lap_r + longint'(gamma_col_q) * lap_c
          + (longint'(1) <<< (sh - 1));
    total = total >>> sh;
    if (total > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (total < -longint'(32'sh7FFF_FFFF) - 1) return 32'h8000_0000;
    return total[VALUE_W-1:0];
  endfunction

  // Work out the results of one accepted grid point and advance the position.
  task automatic predict_point(input logic signed [VALUE_W-1:0] mid,
                               input logic signed [VALUE_W-1:0] bot);
    int unsigned  cur;
    int unsigned  prv;
    bit           last_row;
    grid_result_t res;
    cur = (row_pos & 1) * MAX_COLS;
    prv = ((row_pos + 1) & 1) * MAX_COLS;
    last_row = row_pos >= grid_rows_q;
    if (row_pos >= 1) begin
      res.top = mid_lines[prv + col_pos][VALUE_W-1:0];
      if (row_pos - 1 >= 1 && row_pos - 1 < grid_rows_q && col_pos >= 1 &&
          col_pos < grid_cols_q) begin
        res.top = next_layer_value(mid_lines[cur + col_pos], mid,
                                   mid_lines[prv + col_pos - 1], mid_lines[prv + col_pos + 1],
                                   mid_lines[prv + col_pos], bot_line[col_pos]);
      end
      res.row = ROW_W'(row_pos - 1);
      res.col = COL_W'(col_pos);
      res.run_last = !last_row;
      pending_points.push_back(res);
    end
    mid_lines[cur + col_pos] = mid;
    bot_line[col_pos] = bot;
    if (last_row) begin
      res.top = mid;
      res.row = ROW_W'(row_pos);
      res.col = COL_W'(col_pos);
      res.run_last = 1'b1;
      pending_points.push_back(res);
    end
    if (col_pos >= grid_cols_q) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Called at a falling edge; returns at a falling edge after the transfer and any gap.
  task automatic send_point(input logic [VALUE_W-1:0] mid, input logic [VALUE_W-1:0] bot);
    int unsigned gap;
    point_bus.valid     <= 1'b1;
    point_bus.mid_value <= mid;
    point_bus.bot_value <= bot;
    @(posedge clk_i);
    while (!point_bus.ready) @(posedge clk_i);
    predict_point(mid, bot);
    points_sent++;
    @(negedge clk_i);
    if (!steady_flow) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          point_bus.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [VALUE_W-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [GAMMA_W-1:0] random_gamma();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAMMA_W'(65536);
      2: return '1;
      default: return GAMMA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_frame(input fill_e fill);
    logic [VALUE_W-1:0] mid;
    logic [VALUE_W-1:0] bot;
    int unsigned        n_points;
    n_points = (int'(grid_rows_q) + 1) * (int'(grid_cols_q) + 1);
    for (int unsigned i = 0; i < n_points; i++) begin
      case (fill)
        FILL_SMOOTH: begin
          // Values near +-4.0 keep most results clear of saturation
          mid = 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
          bot = mid + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        end
        FILL_FULL: begin
          mid = $urandom;
          bot = $urandom;
        end
        FILL_EXTREME: begin
          mid = extreme_value();
          bot = extreme_value();
        end
        FILL_HIGH: begin
          mid = 32'h7FFF_FFFF;
          bot = 32'h8000_0000;
        end
        default: begin
          mid = 32'h8000_0000;
          bot = 32'h7FFF_FFFF;
        end
      endcase
      send_point(mid, bot);
    end
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic drain_results();
    point_bus.valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Keep valid high across back-to-back writes; load_setup drops it.
  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      CFG_GRID_ROWS:  grid_rows_q = value[ROW_W-1:0];
      CFG_GRID_COLS:  grid_cols_q = value[COL_W-1:0];
      CFG_GAMMA_ROW:  gamma_row_q = value[GAMMA_W-1:0];
      CFG_GAMMA_COL:  gamma_col_q = value[GAMMA_W-1:0];
      CFG_START_MODE: start_q = value[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_setup(input int unsigned rows, input int unsigned cols,
                            input logic [GAMMA_W-1:0] g_row, input logic [GAMMA_W-1:0] g_col,
                            input logic start);
    drain_results();
    write_register(CFG_GRID_ROWS, CFG_DATA_W'(rows));
    write_register(CFG_GRID_COLS, CFG_DATA_W'(cols));
    write_register(CFG_GAMMA_ROW, g_row);
    write_register(CFG_GAMMA_COL, g_col);
    write_register(CFG_START_MODE, CFG_DATA_W'(start));
    cfg_bus.valid <= 1'b0;
  endtask

  // Reset values of all registers, no write beforehand
  task automatic test_reset_defaults();
    send_frame(FILL_SMOOTH);
    send_frame(FILL_FULL);
  endtask

  // Saturation both ways, then start mode with the largest row gamma
  task automatic test_extreme_values();
    load_setup(2, 2, GAMMA_W'(65536), GAMMA_W'(65536), 1'b0);
    send_frame(FILL_HIGH);
    send_frame(FILL_LOW);
    load_setup(2, 2, '1, '0, 1'b1);
    send_frame(FILL_EXTREME);
  endtask

  // Grids up to the usual minimum: at most point (1,1) is off the boundary
  task automatic test_small_grids();
    for (int unsigned r = 0; r < 3; r++) begin
      for (int unsigned c = 0; c < 3; c++) begin
        load_setup(r, c, random_gamma(), random_gamma(), 1'($urandom_range(0, 1)));
        send_frame(FILL_SMOOTH);
        send_frame(FILL_FULL);
      end
    end
  endtask

  // Tall and wide grids well past the random range
  task automatic test_large_grids();
    load_setup(40, 2, random_gamma(), '1, 1'b0);
    send_frame(FILL_SMOOTH);
    load_setup(2, 60, '1, random_gamma(), 1'b1);
    send_frame(FILL_SMOOTH);
  endtask

  task automatic test_random_frames();
    int unsigned pick;
    int unsigned frames;
    while (points_sent < 900) begin
      load_setup($urandom_range(2, 9), $urandom_range(2, 14), random_gamma(), random_gamma(),
                 1'($urandom_range(0, 1)));
      steady_flow = ($urandom_range(0, 4) == 0);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        pick = $urandom_range(0, 9);
        send_frame(pick < 6 ? FILL_SMOOTH : (pick < 8 ? FILL_FULL : FILL_EXTREME));
      end
    end
    steady_flow = 1'b0;
  endtask

  task automatic check_result();
    grid_result_t want;
    if (pending_points.size() == 0) begin
      $display("%0t ERROR: result with none expected, got top=%h row=%0d col=%0d last=%0b",
               $time, result_bus.top_value, result_bus.row_index, result_bus.col_index,
               result_bus.run_last);
      error_count++;
    end else begin
      want = pending_points.pop_front();
      if (result_bus.top_value !== want.top) begin
        $display("%0t ERROR: top_value expected %h got %h", $time, want.top,
                 result_bus.top_value);
        error_count++;
      end
      if (result_bus.row_index !== want.row) begin
        $display("%0t ERROR: row_index expected %0d got %0d", $time, want.row,
                 result_bus.row_index);
        error_count++;
      end
      if (result_bus.col_index !== want.col) begin
        $display("%0t ERROR: col_index expected %0d got %0d", $time, want.col,
                 result_bus.col_index);
        error_count++;
      end
      if (result_bus.run_last !== want.run_last) begin
        $display("%0t ERROR: run_last expected %0b got %0b", $time, want.run_last,
                 result_bus.run_last);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) check_result();
  end

  // Receiver stalls on a rotating mask, redrawn now and then
  initial begin : result_sink
    logic [15:0] stall_mask;
    int unsigned tick;
    stall_mask = '1;
    tick = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (tick % 40 == 0) begin
        stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1111);
      end
      result_bus.ready <= rst_ni && (steady_flow || stall_mask[tick % 16]);
      tick++;
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("wave_equation_stencil_step: mismatch");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    point_bus.valid = 1'b0;
    point_bus.mid_value = '0;
    point_bus.bot_value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    steady_flow = 1'b0;
    error_count = 0;
    points_sent = 0;
    burst_left = 0;
    grid_rows_q = GRID_ROWS_RST;
    grid_cols_q = GRID_COLS_RST;
    gamma_row_q = GAMMA_RST;
    gamma_col_q = GAMMA_RST;
    start_q = 1'b0;
    row_pos = 0;
    col_pos = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_extreme_values();
    test_small_grids();
    test_large_grids();
    test_random_frames();
    drain_results();
    if (error_count == 0) begin
      $display("wave_equation_stencil_step: match");
    end else begin
      $display("wave_equation_stencil_step: mismatch");
    end
    $finish;
  end

endmodule
